FILE: src/third_order_kernel_filter_assert.svh
// Assertion macros used by the filter's top-level RTL file.
// Each macro expects signals named clk and arst_n in the scope of use.
`ifndef THIRD_ORDER_KERNEL_FILTER_ASSERT_SVH
`define THIRD_ORDER_KERNEL_FILTER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TOKF_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("filter assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define TOKF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("filter assertion failed: next-cycle implication");

`endif

FILE: src/tokf_pkg.sv
`default_nettype none

package tokf_pkg;

	localparam int MAX_LAGS    = 16;
	localparam int SAMPLE_BITS = 16;
	localparam int CUBE_SIZE   = MAX_LAGS * MAX_LAGS * MAX_LAGS;

	localparam int SMP_W   = 16;
	localparam int IDX_W   = 12;
	localparam int CFG_W   = 5;
	localparam int RESP_W  = 48;
	localparam int LAG_W   = (MAX_LAGS > 1) ? $clog2(MAX_LAGS) : 1;
	localparam int LEN_W   = $clog2(MAX_LAGS + 1);
	localparam int ADDR_W  = (CUBE_SIZE > 1) ? $clog2(CUBE_SIZE) : 1;
	localparam int FILL_W  = $clog2(MAX_LAGS + 1);

	localparam int HALF_W   = 2 * SMP_W;
	localparam int PROD_W   = 2 * HALF_W;
	localparam int TRUNC_SH = 29;
	localparam int TERM_W   = PROD_W - TRUNC_SH;
	localparam int ACC_W    = TERM_W + ADDR_W + 2;

	localparam logic [1:0] CMD_SAMPLE  = 2'd0;
	localparam logic [1:0] CMD_KERNEL  = 2'd1;
	localparam logic [1:0] CMD_RESTART = 2'd2;

	localparam logic [CFG_W-1:0] WINDOW_LEN_RESET = CFG_W'(16);

	typedef struct packed {
		logic [1:0]              cmd;
		logic signed [SMP_W-1:0] sample_a;
		logic signed [SMP_W-1:0] sample_b;
		logic signed [SMP_W-1:0] sample_c;
		logic [IDX_W-1:0]        coef_index;
		logic signed [SMP_W-1:0] coef_value;
	} tokf_req_t;

	typedef struct packed {
		logic signed [RESP_W-1:0] response;
		logic                     saturated;
	} tokf_rsp_t;

	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} tokf_mac_ctrl_t;

	typedef struct packed {
		logic                     done;
		logic signed [RESP_W-1:0] response;
		logic                     saturated;
	} tokf_mac_res_t;

	// The low SAMPLE_BITS bits, taken as signed, are moved up to Q1.15.
	function automatic logic signed [SMP_W-1:0] take_sample(input logic [SMP_W-1:0] v);
		return v << (SMP_W - SAMPLE_BITS);
	endfunction

endpackage

`default_nettype wire

FILE: src/third_order_kernel_filter.sv
// Third-order kernel filter over three sample streams.
// Requests arrive on req/req_valid/req_stall and are taken at an edge with req_valid high
// and req_stall low. A kernel write or a restart request leaves the block idle. A sample request
// pushes one sample per stream into the history windows; while fewer than window_len
// samples have arrived since restart it gives no response and leaves the block idle.
// With the window full, the single multiply-accumulate pipeline walks the lag cube in
// kernel memory order, one term per cycle, so the block is busy (req_stall high) through
// the walk, while the pipeline drains and while a finished sum waits for the output
// register to free; rsp_valid rises once the sum has been taken into that register.
// Responses leave on rsp/rsp_valid/rsp_stall through an output register; a stalled
// response holds, and the block still takes requests, but a further response waits in
// the accumulator until the register frees.
// window_len is written on cfg_valid/cfg_data (cfg_ready is always high); the user is to
// write it only while idle, which the block itself does not enforce. Reset empties the
// windows and sets window_len to 16; kernel words are undefined until written.
`default_nettype none

`include "third_order_kernel_filter_assert.svh"

module third_order_kernel_filter
	import tokf_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire tokf_req_t        req,
	input  wire logic             req_valid,
	output logic                  req_stall,
	output tokf_rsp_t             rsp,
	output logic                  rsp_valid,
	input  wire logic             rsp_stall,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [CFG_W-1:0] cfg_data
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_WAIT = 2'd2;

	logic [1:0]              state_q;
	logic [CFG_W-1:0]        window_len_q;
	logic [FILL_W-1:0]       fill_q;
	logic [LAG_W-1:0]        wp_q;
	logic [LAG_W-1:0]        la_q;
	logic [LAG_W-1:0]        lb_q;
	logic [LAG_W-1:0]        lc_q;
	logic [ADDR_W-1:0]       addr_q;
	logic                    rsp_valid_q;
	tokf_rsp_t               rsp_q;

	logic signed [SMP_W-1:0] hist_a_q [MAX_LAGS];
	logic signed [SMP_W-1:0] hist_b_q [MAX_LAGS];
	logic signed [SMP_W-1:0] hist_c_q [MAX_LAGS];

	tokf_mac_ctrl_t          ctrl_s1;
	logic signed [SMP_W-1:0] k_s1;
	logic signed [SMP_W-1:0] a_s1;
	logic signed [SMP_W-1:0] b_s1;
	logic signed [SMP_W-1:0] c_s1;
	tokf_mac_res_t           mac_res;

	logic                    accept;
	logic [LEN_W-1:0]        act_len;
	logic [LEN_W-1:0]        lag_lim;
	logic                    la_end;
	logic                    lb_end;
	logic                    lc_end;
	logic [FILL_W-1:0]       fill_next;
	logic [LAG_W-1:0]        wp_next;
	logic                    coef_wr;
	logic                    rsp_free;
	logic                    take;

	// Slot of the sample that lies lag steps behind the newest one.
	function automatic logic [LAG_W-1:0] hist_idx(input logic [LAG_W-1:0] wp,
		input logic [LAG_W-1:0] lag);
		logic [LAG_W:0] t;
		t = {1'b0, wp} + (LAG_W+1)'(MAX_LAGS - 1) - {1'b0, lag};
		if (t >= (LAG_W+1)'(MAX_LAGS)) begin
			t = t - (LAG_W+1)'(MAX_LAGS);
		end
		return t[LAG_W-1:0];
	endfunction

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		if (window_len_q == '0) begin
			act_len = LEN_W'(1);
		end else if (window_len_q > CFG_W'(MAX_LAGS)) begin
			act_len = LEN_W'(MAX_LAGS);
		end else begin
			act_len = LEN_W'(window_len_q);
		end
	end

	assign lag_lim   = act_len - LEN_W'(1);
	assign la_end    = (LEN_W'(la_q) == lag_lim);
	assign lb_end    = (LEN_W'(lb_q) == lag_lim);
	assign lc_end    = (LEN_W'(lc_q) == lag_lim);
	assign fill_next = (fill_q < FILL_W'(MAX_LAGS)) ? fill_q + FILL_W'(1) : fill_q;
	assign wp_next   = (wp_q == LAG_W'(MAX_LAGS - 1)) ? '0 : wp_q + LAG_W'(1);
	assign coef_wr   = accept && (req.cmd == CMD_KERNEL)
		&& ({1'b0, req.coef_index} < (IDX_W+1)'(CUBE_SIZE));
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign take      = (state_q == ST_WAIT) && mac_res.done && rsp_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q <= WINDOW_LEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			window_len_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			wp_q        <= '0;
			la_q        <= '0;
			lb_q        <= '0;
			lc_q        <= '0;
			addr_q      <= '0;
			rsp_valid_q <= 1'b0;
			ctrl_s1     <= '0;
		end else begin
			ctrl_s1.valid <= (state_q == ST_RUN);
			ctrl_s1.first <= (addr_q == '0);
			ctrl_s1.last  <= la_end && lb_end && lc_end;

			if (take) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (req.cmd)
							CMD_SAMPLE: begin
								wp_q   <= wp_next;
								fill_q <= fill_next;
								if (LEN_W'(fill_next) >= act_len) begin
									state_q <= ST_RUN;
									la_q    <= '0;
									lb_q    <= '0;
									lc_q    <= '0;
									addr_q  <= '0;
								end
							end
							CMD_RESTART: begin
								wp_q   <= '0;
								fill_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_RUN: begin
					// Lags run with lag_a innermost, so the kernel address just counts up.
					addr_q <= addr_q + ADDR_W'(1);
					if (la_end) begin
						la_q <= '0;
						if (lb_end) begin
							lb_q <= '0;
							if (lc_end) begin
								state_q <= ST_WAIT;
							end else begin
								lc_q <= lc_q + LAG_W'(1);
							end
						end else begin
							lb_q <= lb_q + LAG_W'(1);
						end
					end else begin
						la_q <= la_q + LAG_W'(1);
					end
				end
				ST_WAIT: begin
					if (take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (req.cmd == CMD_SAMPLE)) begin
			hist_a_q[wp_q] <= take_sample(req.sample_a);
			hist_b_q[wp_q] <= take_sample(req.sample_b);
			hist_c_q[wp_q] <= take_sample(req.sample_c);
		end
		a_s1 <= hist_a_q[hist_idx(wp_q, la_q)];
		b_s1 <= hist_b_q[hist_idx(wp_q, lb_q)];
		c_s1 <= hist_c_q[hist_idx(wp_q, lc_q)];
		if (take) begin
			rsp_q.response  <= mac_res.response;
			rsp_q.saturated <= mac_res.saturated;
		end
	end

	tokf_coef_ram u_coef_ram (
		.clk     (clk),
		.wr_en   (coef_wr),
		.wr_addr (req.coef_index[ADDR_W-1:0]),
		.wr_data (req.coef_value),
		.rd_addr (addr_q),
		.rd_data (k_s1)
	);

	tokf_mac u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl_s1 (ctrl_s1),
		.k_s1    (k_s1),
		.a_s1    (a_s1),
		.b_s1    (b_s1),
		.c_s1    (c_s1),
		.take    (take),
		.res     (mac_res)
	);

	`TOKF_ASSERT_IMPL(a_issue_in_run, ctrl_s1.valid, $past(state_q) == ST_RUN)
	`TOKF_ASSERT_IMPL(a_run_needs_full_window, state_q == ST_RUN, LEN_W'(fill_q) >= act_len)
	`TOKF_ASSERT_IMPL(a_done_only_waiting, mac_res.done, state_q == ST_WAIT)
	`TOKF_ASSERT_NEXT(a_take_loads_output, take, rsp_valid_q && (state_q == ST_IDLE))

endmodule

`default_nettype wire

FILE: src/tokf_coef_ram.sv
`default_nettype none

module tokf_coef_ram
	import tokf_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    wr_en,
	input  wire logic [ADDR_W-1:0]       wr_addr,
	input  wire logic signed [SMP_W-1:0] wr_data,
	input  wire logic [ADDR_W-1:0]       rd_addr,
	output logic signed [SMP_W-1:0]      rd_data
);

	logic signed [SMP_W-1:0] mem_q [CUBE_SIZE];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

FILE: src/tokf_mac.sv
`default_nettype none

module tokf_mac
	import tokf_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire tokf_mac_ctrl_t          ctrl_s1,
	input  wire logic signed [SMP_W-1:0] k_s1,
	input  wire logic signed [SMP_W-1:0] a_s1,
	input  wire logic signed [SMP_W-1:0] b_s1,
	input  wire logic signed [SMP_W-1:0] c_s1,
	input  wire logic                    take,
	output tokf_mac_res_t                res
);

	tokf_mac_ctrl_t           ctrl_s2;
	tokf_mac_ctrl_t           ctrl_s3;
	logic signed [HALF_W-1:0] ka_s2;
	logic signed [HALF_W-1:0] bc_s2;
	logic signed [PROD_W-1:0] p_s3;
	logic signed [ACC_W-1:0]  acc_q;
	logic                     done_q;

	logic signed [TERM_W-1:0] term;
	logic signed [ACC_W-1:0]  term_ext;
	logic [ACC_W-RESP_W:0]    upper;
	logic                     clip;

	// Arithmetic shift right by 29 is the floor towards minus infinity.
	assign term     = p_s3[PROD_W-1:TRUNC_SH];
	assign term_ext = {{(ACC_W-TERM_W){term[TERM_W-1]}}, term};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s2 <= '0;
			ctrl_s3 <= '0;
			done_q  <= 1'b0;
		end else begin
			ctrl_s2 <= ctrl_s1;
			ctrl_s3 <= ctrl_s2;
			if (ctrl_s3.valid && ctrl_s3.last) begin
				done_q <= 1'b1;
			end else if (take) begin
				done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		ka_s2 <= k_s1 * a_s1;
		bc_s2 <= b_s1 * c_s1;
		p_s3  <= ka_s2 * bc_s2;
		if (ctrl_s3.valid) begin
			acc_q <= ctrl_s3.first ? term_ext : acc_q + term_ext;
		end
	end

	// The sum fits the response when every bit above its sign equals the sign.
	assign upper = acc_q[ACC_W-1:RESP_W-1];
	assign clip  = !((&upper) || !(|upper));

	always_comb begin
		res.done      = done_q;
		res.saturated = clip;
		if (!clip) begin
			res.response = acc_q[RESP_W-1:0];
		end else if (acc_q[ACC_W-1]) begin
			res.response = {1'b1, {(RESP_W-1){1'b0}}};
		end else begin
			res.response = {1'b0, {(RESP_W-1){1'b1}}};
		end
	end

endmodule

`default_nettype wire
